[design/byte_fifo_with_line_extract_core_defines.svh]
// assertion macros for the byte fifo with line extract block
`ifndef BYTE_FIFO_WITH_LINE_EXTRACT_CORE_DEFINES_SVH
`define BYTE_FIFO_WITH_LINE_EXTRACT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define BFLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BFLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BFLE_ASSERT(name, prop, msg)
`define BFLE_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

[design/bfle_pkg.sv]
// shared types and constants for the byte fifo with line extract block
package bfle_pkg;

  localparam int unsigned BFLE_DEPTH = 256;

  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [6:0] LINE_CAP  = 7'd64;
  localparam logic [6:0] LIMIT_RST = 7'd64;

  typedef enum logic [2:0] {
    REQ_PUSH_BYTE = 3'd0,
    REQ_POP_BYTE  = 3'd1,
    REQ_PUSH_WORD = 3'd2,
    REQ_POP_WORD  = 3'd3,
    REQ_FIND      = 3'd4,
    REQ_POP_LINE  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSHW,
    S_POP,
    S_SCAN,
    S_LEMIT,
    S_LTERM
  } fsm_t;

  typedef struct packed {
    logic [31:0] data;
    status_t     status;
    logic        last;
  } res_t;

endpackage

[design/bfle_mem.sv]
// byte store: one write port, one registered read port
module bfle_mem import bfle_pkg::*; #(
  parameter int unsigned DEPTH = BFLE_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule

[design/bfle_ctrl.sv]
// request sequencer: pointers, fill count, scans and result register
`include "byte_fifo_with_line_extract_core_defines.svh"

module bfle_ctrl import bfle_pkg::*; #(
  parameter int unsigned DEPTH = BFLE_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = AW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_req_type,
  input  logic [31:0]   in_data_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_data_out,
  output logic [CW-1:0] out_position,
  output logic [1:0]    out_status,
  output logic          out_last,
  input  logic          cfg_wr_en,
  input  logic [6:0]    cfg_wr_data,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam int unsigned CMPW = ((CW > 7) ? CW : 7) + 1;

  fsm_t          state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0]   data_r, data_nxt;
  logic          is_line_r, is_line_nxt;
  logic [1:0]    pop_end_r, pop_end_nxt;
  logic [6:0]    line_limit_r;

  res_t          res_r, emit_res;
  logic [CW-1:0] pos_r, emit_pos;
  logic          out_valid_r;
  logic          emit;

  logic          accept, slot_free;
  req_t          req;
  logic          is_full, word_room, word_avail, fifo_empty;
  logic          scan_hit, scan_end, line_ok;
  logic [6:0]    limit_eff;
  logic [31:0]   word_asm;

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && slot_free;
  assign accept     = in_valid && in_ready;
  assign req        = req_t'(in_req_type);
  assign fifo_empty = (count_r == '0);
  assign is_full    = (count_r == CW'(DEPTH - 1));
  assign word_room  = (count_r + CW'(4)) < CW'(DEPTH);
  assign word_avail = count_r >= CW'(4);
  assign scan_hit   = (mem_rdata == data_r[7:0]);
  assign scan_end   = (idx_r + CW'(1)) == count_r;
  assign limit_eff  = (line_limit_r > LINE_CAP) ? LINE_CAP : line_limit_r;
  assign line_ok    = (CMPW'(idx_r) + CMPW'(2)) < CMPW'(limit_eff);

  // little-endian assembly of the byte arriving from the store
  always_comb begin
    word_asm = data_r;
    word_asm[{idx_r[1:0], 3'b000} +: 8] = mem_rdata;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_PUSH_WORD: if (word_room) state_nxt = S_PUSHW;
            REQ_POP_BYTE:  if (!fifo_empty) state_nxt = S_POP;
            REQ_POP_WORD:  if (word_avail) state_nxt = S_POP;
            REQ_FIND,
            REQ_POP_LINE:  if (!fifo_empty) state_nxt = S_SCAN;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSHW: begin
        if (idx_r[1:0] == 2'd3) state_nxt = S_IDLE;
      end
      S_POP: begin
        if (idx_r[1:0] == pop_end_r) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          if (is_line_r && scan_hit && line_ok) begin
            state_nxt = (idx_r == '0) ? S_LTERM : S_LEMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LEMIT: begin
        if (slot_free && idx_r == CW'(1)) state_nxt = S_LTERM;
      end
      S_LTERM: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = wp_r;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = rp_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    data_nxt    = data_r;
    is_line_nxt = is_line_r;
    pop_end_nxt = pop_end_r;
    emit        = 1'b0;
    emit_res    = '{data: '0, status: STAT_OK, last: 1'b1};
    emit_pos    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_PUSH_BYTE: begin
              emit = 1'b1;
              if (!is_full) begin
                mem_we        = 1'b1;
                mem_wdata     = in_data_in[7:0];
                wp_nxt        = wp_r + AW'(1);
                count_nxt     = count_r + CW'(1);
                emit_res.data = {24'd0, in_data_in[7:0]};
              end else begin
                emit_res.status = STAT_FULL;
              end
            end
            REQ_PUSH_WORD: begin
              emit = 1'b1;
              if (word_room) begin
                mem_we        = 1'b1;
                mem_wdata     = in_data_in[7:0];
                wp_nxt        = wp_r + AW'(1);
                count_nxt     = count_r + CW'(1);
                data_nxt      = in_data_in;
                idx_nxt       = CW'(1);
                emit_res.data = in_data_in;
              end else begin
                emit_res.status = STAT_FULL;
              end
            end
            REQ_POP_BYTE,
            REQ_POP_WORD: begin
              if ((req == REQ_POP_BYTE) ? !fifo_empty : word_avail) begin
                mem_re      = 1'b1;
                idx_nxt     = '0;
                data_nxt    = '0;
                pop_end_nxt = (req == REQ_POP_BYTE) ? 2'd0 : 2'd3;
              end else begin
                emit            = 1'b1;
                emit_res.status = STAT_EMPTY;
              end
            end
            REQ_FIND,
            REQ_POP_LINE: begin
              if (!fifo_empty) begin
                mem_re      = 1'b1;
                idx_nxt     = '0;
                is_line_nxt = (req == REQ_POP_LINE);
                data_nxt    = {24'd0, (req == REQ_POP_LINE) ? CR_BYTE : in_data_in[7:0]};
              end else begin
                // empty: find reports the fill count, a line is unavailable
                emit            = 1'b1;
                emit_res.status = (req == REQ_POP_LINE) ? STAT_FULL : STAT_OK;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_PUSHW: begin
        mem_we    = 1'b1;
        mem_wdata = data_r[{idx_r[1:0], 3'b000} +: 8];
        wp_nxt    = wp_r + AW'(1);
        count_nxt = count_r + CW'(1);
        idx_nxt   = idx_r + CW'(1);
      end
      S_POP: begin
        rp_nxt    = rp_r + AW'(1);
        count_nxt = count_r - CW'(1);
        data_nxt  = word_asm;
        idx_nxt   = idx_r + CW'(1);
        if (idx_r[1:0] == pop_end_r) begin
          emit          = 1'b1;
          emit_res.data = word_asm;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rp_r + AW'(1);
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          if (!is_line_r) begin
            emit     = 1'b1;
            emit_pos = scan_hit ? idx_r : count_r;
          end else if (scan_hit && line_ok) begin
            // line length stays in idx, first line byte is fetched now if the line is not empty
            mem_re = (idx_r != '0);
          end else begin
            emit            = 1'b1;
            emit_res.status = STAT_FULL;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rp_r + AW'(idx_r) + AW'(1);
          idx_nxt   = idx_r + CW'(1);
        end
      end
      S_LEMIT: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_res.data = {24'd0, mem_rdata};
          emit_res.last = 1'b0;
          rp_nxt        = rp_r + AW'(1);
          count_nxt     = count_r - CW'(1);
          idx_nxt       = idx_r - CW'(1);
          if (idx_r != CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = rp_r + AW'(1);
          end
        end
      end
      S_LTERM: begin
        if (slot_free) begin
          // terminator transfer, the carriage return is dropped
          emit      = 1'b1;
          rp_nxt    = rp_r + AW'(1);
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      rp_r         <= '0;
      count_r      <= '0;
      line_limit_r <= LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        line_limit_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    data_r    <= data_nxt;
    is_line_r <= is_line_nxt;
    pop_end_r <= pop_end_nxt;
    if (emit) begin
      res_r <= emit_res;
      pos_r <= emit_pos;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = res_r.data;
  assign out_position = pos_r;
  assign out_status   = res_r.status;
  assign out_last     = res_r.last;

  `BFLE_ASSERT(a_no_rw_same_cycle, !(mem_we && mem_re), "store read and write in one cycle")
  `BFLE_ASSERT(a_ptr_count_match, (wp_r - rp_r) == count_r[AW-1:0], "pointers disagree with count")
  `BFLE_ASSERT(a_emit_slot_free, !emit || slot_free, "result loaded over a pending transfer")
  `BFLE_ASSERT_NEXT(a_term_consumes, (state_r == S_LTERM) && slot_free, (state_r == S_IDLE) && (count_r == $past(count_r) - CW'(1)), "line terminator not consumed")

endmodule

[design/byte_fifo_with_line_extract_core.sv]
// top level of the byte fifo with line extract block
//
// Requests enter on the in_ channel (valid/ready): push byte, pop byte, push
// word, pop word, find byte, pop line. Results leave on the out_ channel
// (valid/ready), one per request of these kinds, or several for a line pop
// with out_last high on the final one; other type codes give no result.
// cfg_wr_en/cfg_wr_data set the line length limit. The fifo bytes sit in one
// byte store with a registered read port, which paces each request:
//   byte push, failed push or pop, find or line pop on an empty fifo: done at
//   acceptance, back to back while the receiver keeps up
//   word push: one store write per byte, the lowest at acceptance
//   byte pop, word pop: a store read, then one byte per cycle
//   find: a scan byte by byte up to the match, or over the whole fill if none
//   line pop: the same scan for the carriage return, then one transfer per
//   line byte, plus one for the terminator; a failing line pop ends with its scan
// Each result is registered and appears in the cycle after the step that gives
// it; a word push gives its result at acceptance. A stalled receiver holds the
// result register; line bytes wait, and no new request is taken until the
// result slot drains. Reset empties the fifo and sets the limit to 64; store
// contents are left as they are.
module byte_fifo_with_line_extract_core import bfle_pkg::*; #(
  parameter int unsigned DEPTH = BFLE_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = AW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_req_type,
  input  logic [31:0]   in_data_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_data_out,
  output logic [CW-1:0] out_position,
  output logic [1:0]    out_status,
  output logic          out_last,
  input  logic          cfg_wr_en,
  input  logic [6:0]    cfg_wr_data
);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  bfle_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_position (out_position),
    .out_status   (out_status),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  bfle_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
